FILE: rtl/xed_pkg.sv
// ============================================================================
// xed_pkg
// Shared types and constants for the XML character entity decoder.
// ============================================================================
`timescale 1ns / 1ps

package xed_pkg;

    localparam int HELD_DEPTH  = 5;
    localparam int MAX_RESULTS = 6;
    localparam int NUM_NAMED   = 5;
    localparam int ENT_MAX     = 6;
    // Longest decimal reference accepted, in digits (1 to 3)
    localparam int MAX_DIGITS  = 3;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Named entity spellings, first character at index 0
    localparam logic [7:0] ENT_TEXT [NUM_NAMED][ENT_MAX] = '{
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // &gt;
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},  // &apos;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // &quot;
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}   // &amp;
    };
    localparam logic [2:0] ENT_LEN  [NUM_NAMED] = '{3'd4, 3'd4, 3'd6, 3'd6, 3'd5};
    localparam logic [7:0] ENT_CODE [NUM_NAMED] = '{8'h3E, 8'h3C, 8'h27, 8'h22, 8'h26};

    // Pending match state
    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] held;
        logic [2:0]                 count;
        logic [9:0]                 ref_value;
    } dec_state_t;

    // Results caused by one input transaction
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [2:0]                  count;
        logic                        str_end;
    } burst_t;

endpackage

FILE: rtl/xed_step.sv
// ============================================================================
// xed_step
// Combinational decode step: one byte against the pending match, giving the
// bytes to emit and the next match state.
// ============================================================================
`timescale 1ns / 1ps

module xed_step
    import xed_pkg::*;
(
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  dec_state_t cur,
    output dec_state_t nxt,
    output burst_t     burst
);

    logic [ENT_MAX-1:0][7:0]     cand;
    logic [2:0]                  len;
    logic                        partial;
    logic                        full;
    logic [7:0]                  code;
    logic                        dig_upd;
    logic [13:0]                 ref_prod;
    logic [9:0]                  ref_new;
    logic [MAX_RESULTS-1:0][7:0] e1;
    logic [2:0]                  n1;
    logic                        is_digit;

    // Candidate sequence: held bytes followed by the new byte
    assign len      = cur.count + 3'd1;
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign ref_prod = 14'(cur.ref_value) * 14'd10 + 14'(in_byte - CH_ZERO);
    assign ref_new  = ref_prod[9:0];

    always_comb begin
        for (int i = 0; i < ENT_MAX; i++) begin
            if (3'(i) < cur.count && i < HELD_DEPTH) begin
                cand[i] = cur.held[i];
            end else if (3'(i) == cur.count) begin
                cand[i] = in_byte;
            end else begin
                cand[i] = 8'h00;
            end
        end
    end

    // Named and numeric matching
    always_comb begin
        logic m;
        partial = 1'b0;
        full    = 1'b0;
        code    = 8'h00;
        dig_upd = 1'b0;
        for (int k = 0; k < NUM_NAMED; k++) begin
            m = (len <= ENT_LEN[k]);
            for (int i = 0; i < ENT_MAX; i++) begin
                if (3'(i) < len && cand[i] != ENT_TEXT[k][i]) begin
                    m = 1'b0;
                end
            end
            if (m) begin
                if (len == ENT_LEN[k]) begin
                    full = 1'b1;
                    code = ENT_CODE[k];
                end else begin
                    partial = 1'b1;
                end
            end
        end
        if (len == 3'd2 && in_byte == CH_HASH) begin
            partial = 1'b1;
        end else if (len >= 3'd3 && cand[1] == CH_HASH) begin
            // digits held so far = count - 2
            if (is_digit && (cur.count < 3'(MAX_DIGITS + 2))) begin
                partial = 1'b1;
                dig_upd = 1'b1;
            end else if (in_byte == CH_SEMI && cur.count >= 3'd3) begin
                full = 1'b1;
                code = cur.ref_value[7:0];
            end
        end
    end

    // State update and emission list
    always_comb begin
        nxt = cur;
        e1  = '0;
        n1  = 3'd0;
        if (cur.count == 3'd0) begin
            if (in_byte == CH_AMP) begin
                nxt.held[0]   = in_byte;
                nxt.count     = 3'd1;
                nxt.ref_value = 10'd0;
            end else begin
                e1[0] = in_byte;
                n1    = 3'd1;
            end
        end else if (full) begin
            if (code != 8'h00) begin
                e1[0] = code;
                n1    = 3'd1;
            end
            nxt.count     = 3'd0;
            nxt.ref_value = 10'd0;
        end else if (partial && cur.count < 3'(HELD_DEPTH)) begin
            nxt.held[cur.count] = in_byte;
            nxt.count           = cur.count + 3'd1;
            if (dig_upd) begin
                nxt.ref_value = ref_new;
            end
        end else begin
            // Match failed: held bytes pass through
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (3'(i) < cur.count) begin
                    e1[i] = cur.held[i];
                end
            end
            n1            = cur.count;
            nxt.ref_value = 10'd0;
            if (in_byte == CH_AMP) begin
                nxt.held[0] = in_byte;
                nxt.count   = 3'd1;
            end else begin
                e1[cur.count] = in_byte;
                n1            = cur.count + 3'd1;
                nxt.count     = 3'd0;
            end
        end

        // End of string: append what is still held
        burst.bytes   = e1;
        burst.count   = n1;
        burst.str_end = in_last;
        if (in_last) begin
            for (int j = 0; j < MAX_RESULTS; j++) begin
                for (int i = 0; i < HELD_DEPTH; i++) begin
                    if (3'(i) < nxt.count && 3'(j) == n1 + 3'(i)) begin
                        burst.bytes[j] = nxt.held[i];
                    end
                end
            end
            burst.count   = n1 + nxt.count;
            nxt.count     = 3'd0;
            nxt.ref_value = 10'd0;
        end
    end

endmodule

FILE: rtl/xed_out_buf.sv
// ============================================================================
// xed_out_buf
// Result register: holds the bytes of one input transaction and sends them
// one per output transaction.
// ============================================================================
`timescale 1ns / 1ps

module xed_out_buf
    import xed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  burst_t     burst,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] string_end
);

    logic [MAX_RESULTS-1:0][7:0] buf_reg;
    logic [2:0]                  rem_reg;
    logic                        end_reg;
    logic                        pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (rem_reg == 3'd1);
    assign m_tuser  = (rem_reg == 3'd1) && end_reg;
    // New burst may load once the last pending byte leaves this cycle
    assign can_load = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);

    // Remaining count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 3'd0;
        end else if (load) begin
            rem_reg <= burst.count;
        end else if (pop) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    // Byte queue, shifted down on each output transaction
    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= burst.bytes;
            end_reg <= burst.str_end;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= 3'(MAX_RESULTS))
        else $error("result count out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (rem_reg == 3'd0) || (rem_reg == 3'd1 && pop))
        else $error("burst loaded over pending results");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !load) |=> rem_reg == $past(rem_reg) - 3'd1)
        else $error("result count not decremented");

endmodule

FILE: rtl/xml_entity_decoder_core.sv
// Timing: a result is offered in the cycle after its input transaction.
// Throughput: one input per cycle while each byte causes at most one result and
//   m_tready is high; an input causing n results (up to 6) holds s_tready low until
//   its last result leaves the single-entry result register, which drains one byte per cycle while m_tready is high.
// Reset: synchronous active-low aresetn clears the match state and empties
//   the result register; held byte storage is not cleared.
// ============================================================================
// xml_entity_decoder_core
// Streaming XML character entity decoder, one text byte per transaction.
// ============================================================================
`timescale 1ns / 1ps

module xml_entity_decoder_core
    import xed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] string_end
);

    logic [HELD_DEPTH-1:0][7:0] held_reg;
    logic [2:0]                 held_count_reg;
    logic [9:0]                 ref_value_reg;
    dec_state_t                 cur;
    dec_state_t                 nxt;
    burst_t                     burst;
    logic                       s_accept;

    assign s_accept = s_tvalid && s_tready;

    assign cur.held      = held_reg;
    assign cur.count     = held_count_reg;
    assign cur.ref_value = ref_value_reg;

    // Decode step
    xed_step u_step (
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .cur     (cur),
        .nxt     (nxt),
        .burst   (burst)
    );

    // Match state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 3'd0;
            ref_value_reg  <= 10'd0;
        end else if (s_accept) begin
            held_count_reg <= nxt.count;
            ref_value_reg  <= nxt.ref_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            held_reg <= nxt.held;
        end
    end

    // Result register
    xed_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept),
        .burst    (burst),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= 3'(HELD_DEPTH))
        else $error("held count out of range");

    a_ref_needs_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ref_value_reg != 10'd0) |-> (held_count_reg >= 3'd3))
        else $error("reference value without held digits");

    a_idle_no_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (held_count_reg == 3'd0) && (ref_value_reg == 10'd0))
        else $error("match state kept past end of string");

endmodule

FILE: dv/tb_xml_entity_decoder_core.sv
// ============================================================================
// tb_xml_entity_decoder_core
// Streams text strings into the entity decoder and checks every decoded byte,
// its run_last flag and its string_end flag against an in-bench prediction.
// Named entities, decimal references, broken and truncated matches, and
// strings that end inside a match are mixed with plain text. Sender gaps,
// receiver stalls and one long receiver hold-off are applied in phases.
// ============================================================================
`timescale 1ns / 1ps

module tb_xml_entity_decoder_core;
    import xed_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 5;
    localparam int PHASE_ITEMS = 70;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       str_end;
    } dec_char_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // run_last
    logic       m_tuser;            // [0] string_end

    xml_entity_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Text waiting to be sent, decoded bytes waiting to arrive
    text_item_t text_queue[$];
    dec_char_t  expected_chars[$];

    // Decoder state as predicted
    logic [7:0] pend_bytes [HELD_DEPTH];
    int         pend_count = 0;
    logic [9:0] ref_acc    = '0;

    string ent_text [NUM_NAMED] = '{"&gt;", "&lt;", "&apos;", "&quot;", "&amp;"};
    string ent_char    = "><'\"&";
    string ent_letters = "gtlapoqum";

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  err_count = 0;
    int  items_sent = 0;
    int  items_made = 0;
    int  chars_checked = 0;
    int  strings_made = 0;
    int  silent_items = 0;
    int  cycle_cnt = 0;
    text_item_t next_item;
    dec_char_t  want;

    task automatic report_mismatch(string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic void flush_pending(ref logic [7:0] outs[$]);
        for (int i = 0; i < pend_count; i++)
            outs.insert(outs.size(), pend_bytes[i]);
        pend_count = 0;
        ref_acc = '0;
    endfunction

    // Predict the decoded bytes caused by one text byte
    function automatic void decode_text_byte(logic [7:0] b, logic last);
        logic [7:0] outs[$];
        logic [7:0] cand [HELD_DEPTH+1];
        logic [7:0] code;
        int         len;
        int         digits;
        bit         partial;
        bit         full_match;
        bit         same;
        partial = 1'b0;
        full_match = 1'b0;
        code = 8'h00;
        if (pend_count == 0) begin
            if (b == CH_AMP) begin
                pend_bytes[0] = b;
                pend_count = 1;
                ref_acc = '0;
            end else begin
                outs.insert(outs.size(), b);
            end
        end else begin
            for (int i = 0; i < pend_count; i++)
                cand[i] = pend_bytes[i];
            cand[pend_count] = b;
            len = pend_count + 1;
            // named entities
            for (int k = 0; k < NUM_NAMED; k++) begin
                if (len <= ent_text[k].len()) begin
                    same = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (cand[i] != 8'(ent_text[k][i]))
                            same = 1'b0;
                    if (same && len == ent_text[k].len()) begin
                        full_match = 1'b1;
                        code = 8'(ent_char[k]);
                    end else if (same) begin
                        partial = 1'b1;
                    end
                end
            end
            // decimal references
            if (len == 2 && b == CH_HASH) begin
                partial = 1'b1;
            end else if (len >= 3 && cand[1] == CH_HASH) begin
                digits = len - 3;
                if (b >= CH_ZERO && b <= CH_NINE && digits < MAX_DIGITS) begin
                    partial = 1'b1;
                    ref_acc = 10'(int'(ref_acc) * 10 + int'(b - CH_ZERO));
                end else if (b == CH_SEMI && digits >= 1) begin
                    full_match = 1'b1;
                    code = ref_acc[7:0];
                end
            end
            if (full_match) begin
                if (code != 8'h00)
                    outs.insert(outs.size(), code);
                pend_count = 0;
                ref_acc = '0;
            end else if (partial && pend_count < HELD_DEPTH) begin
                pend_bytes[pend_count] = b;
                pend_count++;
            end else begin
                flush_pending(outs);
                if (b == CH_AMP) begin
                    pend_bytes[0] = b;
                    pend_count = 1;
                    ref_acc = '0;
                end else begin
                    outs.insert(outs.size(), b);
                end
            end
        end
        if (last)
            flush_pending(outs);
        if (outs.size() == 0)
            silent_items++;
        foreach (outs[i])
            expected_chars.insert(expected_chars.size(),
                                  '{ch: outs[i],
                                    run_last: (i == outs.size() - 1),
                                    str_end: last && (i == outs.size() - 1)});
    endfunction

    // Driver: offers queued text, predicts on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_text_byte(s_tdata, s_tlast);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (text_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_item = text_queue[0];
                    text_queue.delete(0);
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.ch;
                    s_tlast  <= next_item.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each decoded byte, drives the receiver ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_tdata));
                end else begin
                    want = expected_chars[0];
                    expected_chars.delete(0);
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  m_tdata, want.ch));
                    if (m_tlast !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  m_tlast, want.run_last));
                    if (m_tuser !== want.str_end)
                        report_mismatch($sformatf("string_end %b, want %b",
                                                  m_tuser, want.str_end));
                    chars_checked++;
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Receiver hold-off counter
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_xml_entity_decoder_core NOT OK");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b, bit end_flag);
        text_queue.insert(text_queue.size(), '{ch: b, last: end_flag});
        items_made++;
    endtask

    task automatic push_text(string s, bit end_flag);
        for (int i = 0; i < s.len(); i++)
            push_byte(8'(s[i]), end_flag && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return CH_AMP;
            1: return CH_HASH;
            2: return CH_SEMI;
            3: return CH_ZERO + 8'($urandom_range(0, 9));
            4: return 8'(ent_letters[$urandom_range(0, ent_letters.len() - 1)]);
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // One fragment of text: whole entities, broken ones, or noise and plain bytes
    task automatic push_piece();
        int k;
        int n;
        k = $urandom_range(0, NUM_NAMED - 1);
        case ($urandom_range(0, 11))
            0, 1: push_text(ent_text[k], 1'b0);
            2: begin
                push_text("&#", 1'b0);
                repeat ($urandom_range(1, MAX_DIGITS))
                    push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                push_byte(CH_SEMI, 1'b0);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: push_text("&#255;", 1'b0);
                    1: push_text("&#999;", 1'b0);
                    2: push_text("&#1;", 1'b0);
                    default: push_text("&#512;", 1'b0);
                endcase
            end
            4: begin
                // match cut short, the next fragment or the string end may break, restart or continue it
                n = $urandom_range(1, ent_text[k].len() - 1);
                push_text(ent_text[k].substr(0, n - 1), 1'b0);
            end
            5: begin
                push_text("&#", 1'b0);
                repeat (MAX_DIGITS + 1)
                    push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
            6: begin
                push_text("&#", 1'b0);
                push_byte(noise_byte(), 1'b0);
            end
            7: begin
                n = $urandom_range(1, ent_text[k].len() - 1);
                push_text(ent_text[k].substr(0, n - 1), 1'b0);
                push_byte(noise_byte(), 1'b0);
            end
            8: push_byte(noise_byte(), 1'b0);
            default: begin
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom_range(1, 255)), 1'b0);
            end
        endcase
    endtask

    task automatic push_string();
        repeat ($urandom_range(1, 6))
            push_piece();
        text_queue[text_queue.size() - 1].last = 1'b1;
        strings_made++;
    endtask

    task automatic wait_drained();
        while (text_queue.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    // Stimulus sequence
    initial begin
        int target;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: named entities, too many digits, no digits,
        // zero low byte, and a string ending on a silent reference
        push_text("&lt;", 1'b0);
        push_text("&quot;", 1'b0);
        push_text("&#2555", 1'b0);
        push_text("&#;", 1'b0);
        push_text("&#256;", 1'b0);
        push_text("&#0;", 1'b1);
        strings_made++;
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                3: begin idle_pct = 35; stall_pct = 35; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            target = items_made + PHASE_ITEMS;
            while (items_made < target)
                push_string();
            if (ph == NUM_PHASES - 1) begin
                // receiver holds off while the sender keeps offering
                hold_req = 1'b1;
                @(negedge aclk);
                hold_req = 1'b0;
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d decoded bytes never arrived",
                                      expected_chars.size()));
        $display("Sent %0d text bytes in %0d strings; checked %0d decoded bytes, %0d silent.",
                 items_sent, strings_made, chars_checked, silent_items);
        $display("Phases: no gaps, sender gaps, receiver stalls, both, %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (err_count == 0) begin
            $display("tb_xml_entity_decoder_core OK");
        end else begin
            $display("tb_xml_entity_decoder_core NOT OK");
        end
        $finish;
    end

endmodule
